@@ sv/vmi_pkg.sv @@
// Shared widths, types and constants for the three-axis vector length core.
package vmi_pkg;

    // Bits of each signed component.
    localparam int SAMPLE_WIDTH = 16;
    // Result bits produced by the root cells, most significant first.
    localparam int ROOT_BITS    = 16;
    localparam int LENGTH_W     = 16;
    localparam int SQ_W         = 2 * SAMPLE_WIDTH;
    // The remainder must hold the sum of squares and every trial subtrahend.
    localparam int REM_W        = (SQ_W > 2 * ROOT_BITS) ? SQ_W : 2 * ROOT_BITS;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_axis;
    typedef logic [SAMPLE_WIDTH-1:0]        t_mag;
    typedef logic [SQ_W-1:0]                t_square;
    typedef logic [REM_W-1:0]               t_rem;
    typedef logic [LENGTH_W-1:0]            t_length;

    // Square of the top trial bit: (1 << (ROOT_BITS-1)) squared.
    localparam t_rem ONE_FIRST = t_rem'(1) << (2 * (ROOT_BITS - 1));

    typedef struct packed {
        t_square sq_x;
        t_square sq_y;
        t_square sq_z;
    } t_square_set;

    // Data travelling along the root cells: remainder, scaled partial root
    // and the square of the trial bit of the next cell.
    typedef struct packed {
        t_rem rem;
        t_rem res;
        t_rem one;
    } t_root_slot;

endpackage

@@ sv/vmi_square_stage.sv @@
// Front stage: magnitude of each component and its square, registered.
module vmi_square_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  vmi_pkg::t_axis        i_axis_x,
    input  vmi_pkg::t_axis        i_axis_y,
    input  vmi_pkg::t_axis        i_axis_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output vmi_pkg::t_square_set  o_set
);

    vmi_pkg::t_mag        w_raw_x;
    vmi_pkg::t_mag        w_raw_y;
    vmi_pkg::t_mag        w_raw_z;
    vmi_pkg::t_mag        w_mag_x;
    vmi_pkg::t_mag        w_mag_y;
    vmi_pkg::t_mag        w_mag_z;
    vmi_pkg::t_square_set n_set;
    vmi_pkg::t_square_set r_set;
    logic                 r_valid;

    assign w_raw_x = vmi_pkg::t_mag'(i_axis_x);
    assign w_raw_y = vmi_pkg::t_mag'(i_axis_y);
    assign w_raw_z = vmi_pkg::t_mag'(i_axis_z);

    // Two's complement negation; the most negative sample maps onto its
    // exact magnitude because the result is read as unsigned.
    assign w_mag_x = w_raw_x[vmi_pkg::SAMPLE_WIDTH-1] ? (~w_raw_x + vmi_pkg::t_mag'(1)) : w_raw_x;
    assign w_mag_y = w_raw_y[vmi_pkg::SAMPLE_WIDTH-1] ? (~w_raw_y + vmi_pkg::t_mag'(1)) : w_raw_y;
    assign w_mag_z = w_raw_z[vmi_pkg::SAMPLE_WIDTH-1] ? (~w_raw_z + vmi_pkg::t_mag'(1)) : w_raw_z;

    assign n_set.sq_x = vmi_pkg::t_square'(w_mag_x) * vmi_pkg::t_square'(w_mag_x);
    assign n_set.sq_y = vmi_pkg::t_square'(w_mag_y) * vmi_pkg::t_square'(w_mag_y);
    assign n_set.sq_z = vmi_pkg::t_square'(w_mag_z) * vmi_pkg::t_square'(w_mag_z);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_set <= n_set;
        end
    end

    assign o_valid = r_valid;
    assign o_set   = r_set;

endmodule

@@ sv/vmi_sum_stage.sv @@
// Adds the three squares and opens the root cell chain.
module vmi_sum_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  vmi_pkg::t_square_set  i_set,
    output logic                  o_valid,
    input  logic                  i_ready,
    output vmi_pkg::t_root_slot   o_slot
);

    vmi_pkg::t_rem n_sum;
    vmi_pkg::t_rem r_sum;
    logic          r_valid;

    // Three squares of at most 2^(2W-2) each fit in 2W bits.
    assign n_sum = vmi_pkg::t_rem'(i_set.sq_x) + vmi_pkg::t_rem'(i_set.sq_y)
                 + vmi_pkg::t_rem'(i_set.sq_z);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid    = r_valid;
    assign o_slot.rem = r_sum;
    assign o_slot.res = '0;
    assign o_slot.one = vmi_pkg::ONE_FIRST;

endmodule

@@ sv/vmi_root_cell.sv @@
// One root cell: decides one result bit and passes the remainder onwards.
module vmi_root_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  vmi_pkg::t_root_slot  i_slot,
    output logic                 o_valid,
    input  logic                 i_ready,
    output vmi_pkg::t_root_slot  o_slot
);

    vmi_pkg::t_rem       w_trial;
    logic                w_take;
    vmi_pkg::t_root_slot n_slot;
    vmi_pkg::t_root_slot r_slot;
    logic                r_valid;

    // Keeping the trial bit costs 2*root*bit + bit^2, which is res + one.
    assign w_trial    = i_slot.res + i_slot.one;
    assign w_take     = i_slot.rem >= w_trial;
    assign n_slot.rem = w_take ? (i_slot.rem - w_trial) : i_slot.rem;
    assign n_slot.res = (i_slot.res >> 1) + (w_take ? i_slot.one : '0);
    assign n_slot.one = i_slot.one >> 2;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_slot <= n_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_slot)))
        else $error("root cell lost or altered a blocked transaction");

    a_one_is_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot0(r_slot.one))
        else $error("trial square in root cell is not a power of four");

endmodule

@@ sv/vector3_magnitude_isqrt_core.sv @@
// Top level of the three-axis vector length core (floor of the root of x^2+y^2+z^2).
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------
//  sample   | in        | i_valid / o_stall  | i_axis_x, i_axis_y, i_axis_z
//  length   | out       | o_valid / i_stall  | o_length
//
// One transaction enters per cycle while no stall holds the chain; each
// result passes through the squaring stage, the summing stage and the
// sixteen root cells, one cell for each result bit from the top down.
// Reset is synchronous and clears only the valid bits of the stages; no data
// register is reset and there is no clearing pass.
// Every stage takes a new transaction whenever it is empty or its successor
// moves on, so a held result stalls the chain only once all stages are full.
// o_stall follows i_stall combinationally through that chain of valid bits.
module vector3_magnitude_isqrt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  vmi_pkg::t_axis    i_axis_x,
    input  vmi_pkg::t_axis    i_axis_y,
    input  vmi_pkg::t_axis    i_axis_z,
    output logic              o_valid,
    input  logic              i_stall,
    output vmi_pkg::t_length  o_length
);

    logic                 w_sq_ready;
    logic                 w_sq_valid;
    vmi_pkg::t_square_set w_sq_set;

    // Slot 0 is the output of the summing stage; slot k+1 that of cell k.
    // Ready k is the acceptance of whatever consumes slot k-1, so the last
    // entry is the receiver's own readiness.
    vmi_pkg::t_root_slot  w_slot  [vmi_pkg::ROOT_BITS+1];
    logic                 w_valid [vmi_pkg::ROOT_BITS+1];
    logic                 w_ready [vmi_pkg::ROOT_BITS+2];

    // Squaring stage: magnitudes and squares in one registered step.
    vmi_square_stage u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (w_sq_ready),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_valid  (w_sq_valid),
        .i_ready  (w_ready[0]),
        .o_set    (w_sq_set)
    );

    // Summing stage: the sum of squares becomes the first remainder.
    vmi_sum_stage u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sq_valid),
        .o_ready  (w_ready[0]),
        .i_set    (w_sq_set),
        .o_valid  (w_valid[0]),
        .i_ready  (w_ready[1]),
        .o_slot   (w_slot[0])
    );

    // The root cells: each keeps or drops one trial bit, highest first.
    for (genvar g = 0; g < vmi_pkg::ROOT_BITS; g++) begin : g_cell
        logic w_cell_ready;

        vmi_root_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[g]),
            .o_ready  (w_cell_ready),
            .i_slot   (w_slot[g]),
            .o_valid  (w_valid[g+1]),
            .i_ready  (w_ready[g+2]),
            .o_slot   (w_slot[g+1])
        );

        // The summing stage drives w_ready[0]; cell g reports into w_ready[g+1].
        assign w_ready[g+1] = w_cell_ready;
    end

    // The last cell's register is the output register.
    assign w_ready[vmi_pkg::ROOT_BITS+1] = !i_stall;

    assign o_stall  = !w_sq_ready;
    assign o_valid  = w_valid[vmi_pkg::ROOT_BITS];
    assign o_length = w_slot[vmi_pkg::ROOT_BITS].res[vmi_pkg::LENGTH_W-1:0];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result presented straight after reset");

    a_free_output_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled although the output side is free");

endmodule

@@ sim/tb_vector3_magnitude_isqrt_core.sv @@
// Self-checking testbench for the three-axis vector length core.
module tb_vector3_magnitude_isqrt_core;

    // A run ends if this many cycles pass in a row without a single
    // transaction on either channel. The pipeline is 18 deep and the
    // receiver releases each of its stalls again at random, so the
    // margin is generous.
    localparam int IDLE_LIMIT     = 4000;
    // Cycles allowed after the last expected length before the verdict, so
    // that a spurious extra result would still be caught.
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_VECTORS = 1800;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        vmi_pkg::t_axis   x;
        vmi_pkg::t_axis   y;
        vmi_pkg::t_axis   z;
        vmi_pkg::t_length length;
    } t_vec_length;

    // Keeps the lengths predicted for accepted vectors, in order, and
    // compares each delivered length with the oldest one.
    class t_length_scoreboard;
        t_vec_length pending[$];
        int unsigned compared;
        int unsigned errors;

        // Floor of the root of x^2 + y^2 + z^2, built one result bit at a
        // time from the top, saturating at the largest 16-bit value.
        function vmi_pkg::t_length vector_length(vmi_pkg::t_axis x, vmi_pkg::t_axis y,
                                                 vmi_pkg::t_axis z);
            longint           ax;
            longint           ay;
            longint           az;
            longint unsigned  energy;
            longint unsigned  guess;
            vmi_pkg::t_length root;
            ax = x;
            ay = y;
            az = z;
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            if (az < 0) az = -az;
            energy = ax * ax + ay * ay + az * az;
            root = '0;
            for (int b = vmi_pkg::ROOT_BITS - 1; b >= 0; b--) begin
                guess = root | (longint'(1) << b);
                if (guess * guess <= energy) begin
                    root = vmi_pkg::t_length'(guess);
                end
            end
            return root;
        endfunction

        function void note_vector(vmi_pkg::t_axis x, vmi_pkg::t_axis y, vmi_pkg::t_axis z);
            t_vec_length e;
            e.x = x;
            e.y = y;
            e.z = z;
            e.length = vector_length(x, y, z);
            pending.push_back(e);
        endfunction

        function void report(string what);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("ERROR: %s", what);
            end
        endfunction

        function void check_length(vmi_pkg::t_length got);
            t_vec_length e;
            if (pending.size() == 0) begin
                report($sformatf("length %0d delivered with nothing outstanding", got));
                return;
            end
            e = pending.pop_front();
            compared++;
            if (got !== e.length) begin
                report($sformatf("vector (%0d, %0d, %0d): length expected %0d, got %0d",
                                 e.x, e.y, e.z, e.length, got));
            end
        endfunction

        // Anything still outstanding at the end of the run is a failure.
        function void close_out();
            while (pending.size() != 0) begin
                t_vec_length e;
                e = pending.pop_front();
                report($sformatf("vector (%0d, %0d, %0d): length %0d never delivered",
                                 e.x, e.y, e.z, e.length));
            end
        endfunction
    endclass

    // Stall patterns of the receiver; each is held for a random stretch of
    // cycles before another is chosen.
    typedef enum logic [2:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY,
        RX_TOGGLE
    } t_rx_mode;

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             i_valid  = 1'b0;
    logic             o_stall;
    vmi_pkg::t_axis   i_axis_x = '0;
    vmi_pkg::t_axis   i_axis_y = '0;
    vmi_pkg::t_axis   i_axis_z = '0;
    logic             o_valid;
    logic             i_stall  = 1'b0;
    vmi_pkg::t_length o_length;

    t_length_scoreboard sb = new();

    int unsigned idle_cycles    = 0;
    int unsigned held_cycles    = 0;
    int unsigned directed_count = 0;
    int unsigned random_count   = 0;
    bit          rx_quiet       = 1'b0;

    t_rx_mode    rx_mode        = RX_FREE;
    int unsigned rx_left        = 0;
    int unsigned rx_run         = 0;
    bit          rx_level       = 1'b0;

    vector3_magnitude_isqrt_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_length (o_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Both channels are observed at the rising edge, before the block's own
    // registers update, so each transaction is seen exactly as it was taken.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                sb.note_vector(i_axis_x, i_axis_y, i_axis_z);
                moved = 1'b1;
            end
            if (o_valid === 1'b1 && !i_stall) begin
                sb.check_length(o_length);
                moved = 1'b1;
            end
            if (o_valid === 1'b1 && i_stall) begin
                held_cycles++;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // The receiver changes its stall pattern every so often, so that stalls
    // land on every fill level of the pipeline, with free-running stretches
    // in between. It stops stalling altogether once the run is draining.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 4));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        if (rx_quiet) begin
            i_stall <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_LIGHT:  i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
                RX_BURSTY: begin
                    if (rx_run == 0) begin
                        rx_level = !rx_level;
                        rx_run = $urandom_range(1, 30);
                    end
                    rx_run--;
                    i_stall <= rx_level;
                end
                default:   i_stall <= !i_stall;
            endcase
        end
    end

    // Presents one vector and holds it, unchanged, until the block takes it.
    task automatic push_vector(vmi_pkg::t_axis x, vmi_pkg::t_axis y, vmi_pkg::t_axis z);
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_axis_x <= x;
        i_axis_y <= y;
        i_axis_z <= z;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Drops valid for roughly the given number of cycles; the payload is
    // scrambled meanwhile, as it carries no meaning while valid is low.
    task automatic sender_gap(int unsigned cycles);
        if (cycles != 0) begin
            @(negedge i_clk);
            i_valid  <= 1'b0;
            i_axis_x <= vmi_pkg::t_axis'($urandom);
            i_axis_y <= vmi_pkg::t_axis'($urandom);
            i_axis_z <= vmi_pkg::t_axis'($urandom);
            repeat (cycles - 1) @(posedge i_clk);
        end
    endtask

    task automatic directed(vmi_pkg::t_axis x, vmi_pkg::t_axis y, vmi_pkg::t_axis z);
        push_vector(x, y, z);
        directed_count++;
    endtask

    // One component drawn according to the flavour of the vector.
    function automatic vmi_pkg::t_axis pick_axis(int unsigned flavour);
        case (flavour)
            0: return vmi_pkg::t_axis'($urandom);
            1: return vmi_pkg::t_axis'($urandom_range(0, 64)) - vmi_pkg::t_axis'(32);
            2: return $urandom_range(0, 1)
                      ? vmi_pkg::t_axis'(16'sh7fff - $urandom_range(0, 15))
                      : vmi_pkg::t_axis'(16'sh8000 + $urandom_range(0, 15));
            default: return $urandom_range(0, 1) ? vmi_pkg::t_axis'($urandom_range(0, 255))
                                                 : vmi_pkg::t_axis'($urandom);
        endcase
    endfunction

    task automatic random_vector();
        vmi_pkg::t_axis x;
        vmi_pkg::t_axis y;
        vmi_pkg::t_axis z;
        int unsigned    flavour;
        vmi_pkg::t_axis k;
        flavour = $urandom_range(0, 5);
        case (flavour)
            3: begin
                // A single non-zero component: the length is its magnitude.
                x = vmi_pkg::t_axis'($urandom);
                y = '0;
                z = '0;
            end
            4: begin
                // A perfect square or the value just above it, either sign.
                k = vmi_pkg::t_axis'($urandom_range(0, 32767));
                x = $urandom_range(0, 1) ? -k : k;
                y = vmi_pkg::t_axis'($urandom_range(0, 1));
                z = '0;
            end
            5: begin
                x = pick_axis($urandom_range(0, 3));
                y = pick_axis($urandom_range(0, 3));
                z = pick_axis($urandom_range(0, 3));
            end
            default: begin
                x = pick_axis(flavour);
                y = pick_axis(flavour);
                z = pick_axis(flavour);
            end
        endcase
        // Rotate the components so that no axis is favoured.
        case ($urandom_range(0, 2))
            0: push_vector(x, y, z);
            1: push_vector(z, x, y);
            default: push_vector(y, z, x);
        endcase
        random_count++;
    endtask

    // Watchdog: ends the run if traffic stops on both channels.
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles, %0d lengths outstanding",
                 IDLE_LIMIT, sb.pending.size());
        $display("tb_vector3_magnitude_isqrt_core: done, errors");
        $finish;
    end

    initial begin
        int unsigned burst;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vectors: zero, the field extremes (the most negative value
        // must give its exact magnitude), sign handling, exact squares and
        // sums just short of a perfect square.
        directed(16'sd0, 16'sd0, 16'sd0);
        directed(16'sd1, 16'sd0, 16'sd0);
        directed(-16'sd1, -16'sd1, -16'sd1);
        directed(16'sd32767, 16'sd0, 16'sd0);
        directed(16'sd0, -16'sd32768, 16'sd0);
        directed(16'sd0, 16'sd0, -16'sd32768);
        directed(16'sd32767, 16'sd32767, 16'sd32767);
        directed(-16'sd32768, -16'sd32768, -16'sd32768);
        directed(16'sd32767, -16'sd32768, 16'sd32767);
        directed(-16'sd32767, -16'sd32767, -16'sd32767);
        directed(16'sd3, -16'sd4, 16'sd0);
        directed(16'sd2, 16'sd3, -16'sd6);
        directed(-16'sd1, 16'sd2, -16'sd2);
        directed(16'sd2, 16'sd2, 16'sd4);
        directed(16'sd1, 16'sd1, 16'sd0);
        directed(16'sd181, 16'sd181, 16'sd0);
        directed(16'sd30000, 16'sd16000, -16'sd1);
        directed(16'sh5555, -16'sh5556, 16'sh2aaa);
        directed(16'sh00ff, 16'shff00, 16'sh0f0f);
        directed(-16'sd32768, 16'sd0, 16'sd1);

        // Random vectors, sent in bursts with gaps of random length. Some
        // bursts run back to back with no gap at all.
        while (random_count < RANDOM_VECTORS) begin
            burst = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 40);
            repeat (burst) random_vector();
            sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        rx_quiet = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();

        $display("Covered %0d vectors, %0d directed and %0d random, with %0d lengths compared.",
                 directed_count + random_count, directed_count, random_count, sb.compared);
        $display("The receiver held a ready length for %0d cycles; %0d errors were found.",
                 held_cycles, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_vector3_magnitude_isqrt_core: done, clean");
        end else begin
            $display("tb_vector3_magnitude_isqrt_core: done, errors");
        end
        $finish;
    end

endmodule
